// File: rtl/core/r2fft_pkg.sv
package r2fft_pkg;

   localparam int MaxLog2Points = 6;
   localparam int StoreDepth = 1 << MaxLog2Points;
   localparam int AddrWidth = MaxLog2Points;
   localparam int ValWidth = 24;
   localparam logic signed [ValWidth-1:0] ValMax = 24'sh7fffff;
   localparam logic signed [ValWidth-1:0] ValMin = -24'sh800000;

   // register indexes
   localparam logic [1:0] CsrPointsLog2 = 2'd0;
   localparam logic [1:0] CsrNormMode = 2'd1;
   localparam logic [1:0] CsrInverse = 2'd2;

   // normalization codes
   localparam logic [1:0] NormNone = 2'd0;
   localparam logic [1:0] NormOrtho = 2'd1;
   localparam logic [1:0] NormFull = 2'd2;

   typedef struct packed {
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] bin_re;
      logic signed [23:0] bin_im;
      logic last_bin;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREP,
      ST_BFLY_RD,
      ST_BFLY_MUL,
      ST_BFLY_WR,
      ST_OUT_RD,
      ST_OUT_MUL,
      ST_OUT_SHOW
   } state_type;

   // request to the shared complex multiply unit
   typedef struct packed {
      logic signed [23:0] x_re;
      logic signed [23:0] x_im;
      logic signed [16:0] w_re;
      logic signed [16:0] w_im;
   } cmul_req_type;

   function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
      logic signed [23:0] r;
      if (v > 50'sd8388607) r = ValMax;
      else if (v < -50'sd8388608) r = ValMin;
      else r = v[23:0];
      return r;
   endfunction

   // floor((p + 2^14) / 2^15)
   function automatic logic signed [49:0] rnd15(input logic signed [49:0] p);
      logic signed [49:0] q;
      q = p + 50'sd16384;
      return q >>> 15;
   endfunction

   function automatic logic [15:0] quarter_sine(input logic [4:0] m);
      logic [15:0] r;
      case (m)
         5'd0: r = 16'd0;
         5'd1: r = 16'd3212;
         5'd2: r = 16'd6393;
         5'd3: r = 16'd9512;
         5'd4: r = 16'd12540;
         5'd5: r = 16'd15447;
         5'd6: r = 16'd18205;
         5'd7: r = 16'd20788;
         5'd8: r = 16'd23170;
         5'd9: r = 16'd25330;
         5'd10: r = 16'd27246;
         5'd11: r = 16'd28899;
         5'd12: r = 16'd30274;
         5'd13: r = 16'd31357;
         5'd14: r = 16'd32138;
         5'd15: r = 16'd32610;
         5'd16: r = 16'd32767;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] ortho_scale(input logic [2:0] l);
      logic [16:0] r;
      case (l)
         3'd0: r = 17'd32768;
         3'd1: r = 17'd23170;
         3'd2: r = 17'd16384;
         3'd3: r = 17'd11585;
         3'd4: r = 17'd8192;
         3'd5: r = 17'd5793;
         default: r = 17'd4096;
      endcase
      return r;
   endfunction

   function automatic logic [AddrWidth-1:0] bitrev(input logic [AddrWidth-1:0] i,
                                                   input logic [2:0] len);
      logic [AddrWidth-1:0] r;
      r = '0;
      for (int k = 0; k < AddrWidth; k++) begin
         if (k < len) r[len - 1 - k] = i[k];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/r2fft_cmul.sv
module r2fft_cmul
   import r2fft_pkg::*;
(
   input  logic clock,
   input  cmul_req_type cmul_req,
   output logic signed [23:0] prod_re,
   output logic signed [23:0] prod_im
);

   logic signed [49:0] pr_ff, pi_ff;
   logic signed [49:0] pr_in, pi_in;
   logic signed [40:0] wr_xr, wi_xi, wr_xi, wi_xr;

   // products registered before rounding
   always_comb begin
      wr_xr = cmul_req.w_re * cmul_req.x_re;
      wi_xi = cmul_req.w_im * cmul_req.x_im;
      wr_xi = cmul_req.w_re * cmul_req.x_im;
      wi_xr = cmul_req.w_im * cmul_req.x_re;
      pr_in = 50'(wr_xr) - 50'(wi_xi);
      pi_in = 50'(wr_xi) + 50'(wi_xr);
   end

   always_ff @(posedge clock) begin
      pr_ff <= pr_in;
      pi_ff <= pi_in;
   end

   assign prod_re = sat24(rnd15(pr_ff));
   assign prod_im = sat24(rnd15(pi_ff));

endmodule

// File: rtl/core/radix2_fft_engine.sv
// radix-2 decimation-in-time fft engine, up to 64 complex points
// channels: req_ carries one Q1.15 sample per beat, rsp_ returns one Q9.15
// bin per beat with last_bin on the final bin, csr_ writes points_log2,
// norm_mode and inverse by index; the user must do so only while the
// engine is idle, which the block does not enforce. samples load one per
// cycle into a bit-reversed store; req_ready stays high while loading. the
// beat completing a frame of N samples starts the transform (req_ready low).
// transform: a copy pass, then (N/2)*log2(N) butterflies, each a read,
// multiply and write back through one shared complex multiplier, then N
// bins, each read, scaled and then held until rsp_ready.
// a stalled receiver simply holds the current bin; nothing is lost.
// reset empties the frame and restores points_log2=6, norm none, forward.
module radix2_fft_engine
   import r2fft_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_data
);

   state_type state_ff, state_in;
   logic [2:0] plog_ff;
   logic [1:0] norm_ff;
   logic inv_ff;
   logic [6:0] count_ff, count_in;
   logic [2:0] len_ff, len_in;
   logic frame_inv_ff, frame_inv_in;
   logic [16:0] factor_ff, factor_in;
   logic do_scale_ff, do_scale_in;
   logic [2:0] stage_ff, stage_in;
   logic [5:0] idx_ff, idx_in;

   // raw sample store and working copy
   logic [47:0] store_mem [StoreDepth];
   logic [47:0] store_rd_ff;
   logic signed [23:0] wre_mem [StoreDepth];
   logic signed [23:0] wim_mem [StoreDepth];
   logic signed [23:0] ap_re_ff, ap_im_ff, aq_re_ff, aq_im_ff;

   logic [2:0] len_now;
   logic [6:0] n_now;
   logic [AddrWidth-1:0] ld_addr;
   logic [5:0] n_m1;
   logic [5:0] p_addr, q_addr, half;
   logic [4:0] tw_m;
   logic signed [16:0] tw_re, tw_im;
   cmul_req_type cmul_req;
   logic signed [23:0] prod_re, prod_im;
   logic load_beat;
   logic signed [23:0] cp_im;
   logic signed [23:0] out_re, out_im;
   rsp_payload_type rsp_in;
   logic [1:0] mode;

   assign len_now = (plog_ff > 3'(MaxLog2Points)) ? 3'(MaxLog2Points) : plog_ff;
   assign n_now = 7'd1 << len_now;
   assign ld_addr = bitrev(count_ff[AddrWidth-1:0] & 6'(n_now - 7'd1), len_now);
   assign load_beat = req_valid && req_ready;
   assign n_m1 = 6'((7'd1 << len_ff) - 7'd1);

   // butterfly addressing: idx counts butterflies within a stage
   always_comb begin
      half = 6'd1 << stage_ff;
      p_addr = ((idx_ff >> stage_ff) << (stage_ff + 3'd1)) | (idx_ff & 6'(half - 6'd1));
      q_addr = p_addr | half;
      tw_m = 5'(6'(idx_ff & 6'(half - 6'd1)) << (3'd5 - stage_ff));
   end

   // twiddle from quarter sine table
   always_comb begin
      if (tw_m <= 5'd16) begin
         tw_re = 17'(quarter_sine(5'd16 - tw_m));
         tw_im = -17'(quarter_sine(tw_m));
      end else begin
         tw_re = -17'(quarter_sine(tw_m - 5'd16));
         tw_im = -17'(quarter_sine(5'(6'd32 - 6'(tw_m))));
      end
   end

   // shared multiplier: butterfly twiddle or output scale
   always_comb begin
      if (state_ff == ST_OUT_MUL || state_ff == ST_OUT_SHOW) begin
         cmul_req.x_re = ap_re_ff;
         cmul_req.x_im = ap_im_ff;
         cmul_req.w_re = factor_ff;
         cmul_req.w_im = '0;
      end else begin
         cmul_req.x_re = aq_re_ff;
         cmul_req.x_im = aq_im_ff;
         cmul_req.w_re = tw_re;
         cmul_req.w_im = tw_im;
      end
   end

   r2fft_cmul u_cmul (
      .clock(clock),
      .cmul_req(cmul_req),
      .prod_re(prod_re),
      .prod_im(prod_im)
   );

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         plog_ff <= 3'd6;
         norm_ff <= NormNone;
         inv_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrPointsLog2: plog_ff <= csr_data;
            CsrNormMode: norm_ff <= csr_data[1:0];
            CsrInverse: inv_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sample store write and read port
   always_ff @(posedge clock) begin
      if (load_beat) store_mem[ld_addr] <= {24'(signed'(req_payload.sample_im)),
                                            24'(signed'(req_payload.sample_re))};
      store_rd_ff <= store_mem[idx_ff];
   end

   assign cp_im = frame_inv_ff ? sat24(-50'(signed'(store_rd_ff[47:24])))
                               : store_rd_ff[47:24];

   // working copy: write port driven by copy pass or butterfly write back
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP && count_ff != 7'd0) begin
         wre_mem[6'(count_ff - 7'd1)] <= store_rd_ff[23:0];
         wim_mem[6'(count_ff - 7'd1)] <= cp_im;
      end else if (state_ff == ST_BFLY_WR) begin
         wre_mem[p_addr] <= sat24(50'(ap_re_ff) + 50'(prod_re));
         wim_mem[p_addr] <= sat24(50'(ap_im_ff) + 50'(prod_im));
         wre_mem[q_addr] <= sat24(50'(ap_re_ff) - 50'(prod_re));
         wim_mem[q_addr] <= sat24(50'(ap_im_ff) - 50'(prod_im));
      end
   end

   // operand reads: butterfly pair or output bin
   always_ff @(posedge clock) begin
      if (state_ff == ST_BFLY_RD) begin
         ap_re_ff <= wre_mem[p_addr];
         ap_im_ff <= wim_mem[p_addr];
      end else if (state_ff == ST_OUT_RD) begin
         ap_re_ff <= wre_mem[idx_ff];
         ap_im_ff <= wim_mem[idx_ff];
      end
      aq_re_ff <= wre_mem[q_addr];
      aq_im_ff <= wim_mem[q_addr];
   end

   // output scaling and conjugation
   always_comb begin
      out_re = do_scale_ff ? prod_re : ap_re_ff;
      out_im = do_scale_ff ? prod_im : ap_im_ff;
      if (frame_inv_ff) out_im = sat24(-50'(out_im));
      rsp_in.bin_re = out_re;
      rsp_in.bin_im = out_im;
      rsp_in.last_bin = (idx_ff == n_m1);
   end

   always_comb begin
      mode = (norm_ff == 2'd3) ? NormNone : norm_ff;
      if (inv_ff) begin
         if (mode == NormNone) mode = NormFull;
         else if (mode == NormFull) mode = NormNone;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      len_in = len_ff;
      frame_inv_in = frame_inv_ff;
      factor_in = factor_ff;
      do_scale_in = do_scale_ff;
      stage_in = stage_ff;
      idx_in = idx_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (load_beat) begin
               count_in = count_ff + 7'd1;
               if (count_ff + 7'd1 >= n_now) begin
                  state_in = ST_PREP;
                  count_in = '0;
                  idx_in = '0;
                  len_in = len_now;
                  frame_inv_in = inv_ff;
                  if (mode == NormOrtho) factor_in = ortho_scale(len_now);
                  else if (mode == NormFull) factor_in = 17'(17'd32768 >> len_now);
                  else factor_in = 17'd32768;
                  do_scale_in = !((mode == NormOrtho && len_now == 3'd0) ||
                                  (mode == NormFull && len_now == 3'd0) ||
                                  mode == NormNone);
               end
            end
         end
         ST_PREP: begin
            // idx reads store, count lags by one for write
            count_in = count_ff + 7'd1;
            idx_in = idx_ff + 6'd1;
            if (count_ff == (7'd1 << len_ff)) begin
               count_in = '0;
               idx_in = '0;
               stage_in = '0;
               state_in = (len_ff == 3'd0) ? ST_OUT_RD : ST_BFLY_RD;
            end
         end
         ST_BFLY_RD: state_in = ST_BFLY_MUL;
         ST_BFLY_MUL: state_in = ST_BFLY_WR;
         ST_BFLY_WR: begin
            state_in = ST_BFLY_RD;
            idx_in = idx_ff + 6'd1;
            if (7'(idx_ff) + 7'd1 == (7'd1 << len_ff) >> 1) begin
               idx_in = '0;
               stage_in = stage_ff + 3'd1;
               if (stage_ff + 3'd1 == len_ff) state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_MUL;
         ST_OUT_MUL: state_in = ST_OUT_SHOW;
         ST_OUT_SHOW: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 6'd1;
               if (idx_ff == n_m1) begin
                  state_in = ST_LOAD;
                  idx_in = '0;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         idx_ff <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      frame_inv_ff <= frame_inv_in;
      factor_ff <= factor_in;
      do_scale_ff <= do_scale_in;
   end

   // bin shown from held operand and held product
   assign rsp_valid = (state_ff == ST_OUT_SHOW);
   assign rsp_payload = rsp_in;

endmodule

// File: rtl/core/r2fft_checker.sv
module r2fft_checker
   import r2fft_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_ready,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_payload_type rsp_payload
);

   // no sample taken while a bin is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("sample accepted during output");

   // stalled bin holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("bin changed under stall");

   // after the last bin the engine is ready again
   a_last_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.last_bin |=> req_ready)
      else $error("not ready after frame");

   // output idle after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("bin after reset");

endmodule

bind radix2_fft_engine r2fft_checker u_r2fft_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);
